// File: design/ird_pkg.sv
// Package for the integer to radix digits formatter.
// Holds the shared widths, ASCII codes and the digit to character mapping.
// No dependencies.
package ird_pkg;

  localparam int DEFAULT_VALUE_WIDTH = 32;
  localparam int RADIX_W = 6;
  localparam int CHAR_W = 7;

  localparam logic [RADIX_W-1:0] RADIX_MIN = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX = RADIX_W'(36);
  localparam logic [RADIX_W-1:0] DECIMAL_DIGITS = RADIX_W'(10);

  localparam logic [CHAR_W-1:0] CHAR_ZERO = CHAR_W'(48);
  localparam logic [CHAR_W-1:0] CHAR_A = CHAR_W'(97);
  localparam logic [CHAR_W-1:0] CHAR_MINUS = CHAR_W'(45);

  typedef logic [RADIX_W-1:0] radix_t;
  typedef logic [CHAR_W-1:0] char_t;

  function automatic char_t digit_char(input radix_t d);
    if (d < DECIMAL_DIGITS) begin
      return CHAR_ZERO + CHAR_W'(d);
    end
    return CHAR_A + CHAR_W'(d - DECIMAL_DIGITS);
  endfunction

endpackage

// File: design/integer_to_radix_digits.sv
// Formats a signed integer as ASCII text in a base from 2 to 36, one character per result.
// Each digit comes from one division in the bit-serial divider. After the last one, the minus sign
// is sent from S_SIGN when negative, and each digit then passes S_LOAD and S_OUT. While busy is high
// a new start is ignored; the next request is accepted once the controller is back in idle.
// Results appear for one cycle each and the receiver cannot stall them.
// Synchronous reset returns the controller to idle; it uses ird_pkg and ird_serial_div.
module integer_to_radix_digits #(
  parameter int VALUE_WIDTH = ird_pkg::DEFAULT_VALUE_WIDTH
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  logic [VALUE_WIDTH-1:0] value,
  input  ird_pkg::radix_t        radix,
  output logic                   strobe,
  output ird_pkg::char_t         text_char,
  output logic                   is_last
);
  import ird_pkg::*;

  localparam int AW = $clog2(VALUE_WIDTH);
  localparam int ST_W = 3;
  localparam logic [ST_W-1:0] S_IDLE = 3'd0;
  localparam logic [ST_W-1:0] S_DIV = 3'd1;
  localparam logic [ST_W-1:0] S_SIGN = 3'd2;
  localparam logic [ST_W-1:0] S_LOAD = 3'd3;
  localparam logic [ST_W-1:0] S_OUT = 3'd4;

  logic [ST_W-1:0]        state;
  logic [ST_W-1:0]        state_next;
  logic                   neg;
  radix_t                 base;
  radix_t                 base_in;
  logic [AW-1:0]          count;
  logic [AW-1:0]          ptr;
  logic [VALUE_WIDTH-1:0] magnitude;
  logic                   div_load;
  logic [VALUE_WIDTH-1:0] div_dividend;
  logic                   div_done;
  logic [VALUE_WIDTH-1:0] div_quotient;
  radix_t                 div_remainder;
  logic                   accept;
  logic                   quotient_zero;
  char_t                  digit_mem [VALUE_WIDTH];
  char_t                  rd_data;

  assign accept = start && (state == S_IDLE);
  assign busy = state != S_IDLE;
  assign magnitude = value[VALUE_WIDTH-1] ? (~value + VALUE_WIDTH'(1)) : value;
  assign quotient_zero = div_quotient == '0;

  always_comb begin
    if (radix < RADIX_MIN) begin
      base_in = RADIX_MIN;
    end else if (radix > RADIX_MAX) begin
      base_in = RADIX_MAX;
    end else begin
      base_in = radix;
    end
  end

  assign div_load = accept || ((state == S_DIV) && div_done && !quotient_zero);
  assign div_dividend = (state == S_IDLE) ? magnitude : div_quotient;

  ird_serial_div #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_div (
    .clk(clk),
    .rst(rst),
    .load(div_load),
    .dividend(div_dividend),
    .divisor((state == S_IDLE) ? base_in : base),
    .done(div_done),
    .quotient(div_quotient),
    .remainder(div_remainder)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) state_next = S_DIV;
      end
      S_DIV: begin
        if (div_done && quotient_zero) state_next = neg ? S_SIGN : S_LOAD;
      end
      S_SIGN: state_next = S_LOAD;
      S_LOAD: state_next = S_OUT;
      S_OUT: begin
        state_next = (ptr == '0) ? S_IDLE : S_LOAD;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      ptr <= '0;
    end else begin
      state <= state_next;
      if (accept) begin
        count <= '0;
      end else if ((state == S_DIV) && div_done) begin
        count <= count + AW'(1);
        if (quotient_zero) ptr <= count;
      end else if ((state == S_OUT) && (ptr != '0)) begin
        ptr <= ptr - AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      neg <= value[VALUE_WIDTH-1];
      base <= base_in;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_DIV) && div_done) begin
      digit_mem[count] <= digit_char(div_remainder);
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= digit_mem[ptr];
  end

  assign strobe = (state == S_SIGN) || (state == S_OUT);
  assign text_char = (state == S_SIGN) ? CHAR_MINUS : rd_data;
  assign is_last = (state == S_OUT) && (ptr == '0);

endmodule

// File: design/ird_serial_div.sv
// Bit-serial restoring divider: one quotient bit per cycle, remainder below the radix.
// Depends on ird_pkg for the radix width.
module ird_serial_div #(
  parameter int VALUE_WIDTH = ird_pkg::DEFAULT_VALUE_WIDTH
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   load,
  input  logic [VALUE_WIDTH-1:0] dividend,
  input  ird_pkg::radix_t        divisor,
  output logic                   done,
  output logic [VALUE_WIDTH-1:0] quotient,
  output ird_pkg::radix_t        remainder
);
  import ird_pkg::*;

  localparam int CNT_W = $clog2(VALUE_WIDTH);
  localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(VALUE_WIDTH - 1);

  logic             running;
  logic [CNT_W-1:0] bit_count;
  logic [RADIX_W:0] trial;
  logic             fits;

  assign trial = {remainder, quotient[VALUE_WIDTH-1]};
  assign fits = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done <= 1'b0;
      bit_count <= '0;
    end else begin
      done <= 1'b0;
      if (load) begin
        running <= 1'b1;
        bit_count <= '0;
      end else if (running) begin
        bit_count <= bit_count + CNT_W'(1);
        if (bit_count == LAST_BIT) begin
          running <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      quotient <= dividend;
      remainder <= '0;
    end else if (running) begin
      quotient <= {quotient[VALUE_WIDTH-2:0], fits};
      remainder <= fits ? RADIX_W'(trial - {1'b0, divisor}) : trial[RADIX_W-1:0];
    end
  end

endmodule
